// ===== hdl/slti_pkg.sv =====
// Shared types and constants for the symbol label to integer unit.
`default_nettype none

package slti_pkg;

    localparam int MAX_RADIX = 16;
    localparam int WIN_AW    = $clog2(MAX_RADIX);
    localparam int RADIX_W   = 5;
    localparam int ENC_W     = 2;
    localparam int SYM_W     = 4;
    localparam int VAL_W     = 32;
    localparam int CFG_IW    = 1;
    localparam int CFG_DW    = 5;

    localparam logic [CFG_IW-1:0] REG_ENCODING = 1'd0;
    localparam logic [CFG_IW-1:0] REG_RADIX    = 1'd1;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd3;

    typedef enum logic [ENC_W-1:0] {
        ENC_DIRECT = 2'd0,
        ENC_GRAY   = 2'd1,
        ENC_UNIQUE = 2'd2,
        ENC_FIB    = 2'd3
    } enc_t;

    typedef enum logic [2:0] {
        ST_BUILD,
        ST_IDLE,
        ST_FIB_ADD,
        ST_FIB_RD2,
        ST_FIB_RD1,
        ST_FIB_W2,
        ST_FIB_REC
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TAKE,
        OP_FIB_ADD,
        OP_FIB_RD2,
        OP_FIB_RD1,
        OP_FIB_W2,
        OP_FIB_REC,
        OP_BUILD
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [WIN_AW-1:0]   idx;
    } dp_cmd_t;

    typedef struct packed {
        logic                fib_mode;   // fibonacci encoding with a usable window
        logic                radix_is3;
        logic [RADIX_W-1:0]  radix_eff;
        logic                out_free;
        logic                last;
        logic                cfg_hit;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/slti_dp.sv =====
// Datapath: configuration, accumulator, fibonacci window memory and result register.
`default_nettype none

module slti_dp
    import slti_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dp_cmd_t             cmd,
    output dp_status_t               status,
    input  wire logic [SYM_W-1:0]    symbol,
    input  wire logic                final_symbol,
    input  wire logic                cfg_we,
    input  wire logic [CFG_IW-1:0]   cfg_index,
    input  wire logic [CFG_DW-1:0]   cfg_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [VAL_W-1:0]         label_value
);

    enc_t               enc_reg;
    logic [RADIX_W-1:0] radix_reg;
    logic [RADIX_W-1:0] r_eff;

    logic [VAL_W-1:0]   acc_reg, acc_next;
    logic               par_reg, par_next;
    logic [VAL_W-1:0]   a_reg, a_next;
    logic [VAL_W-1:0]   b_reg, b_next;
    logic [VAL_W-1:0]   rdata_reg;
    logic [SYM_W-1:0]   sym_reg;
    logic               last_reg;
    logic               outv_reg, outv_next;
    logic [VAL_W-1:0]   outd_reg, outd_next;

    logic [VAL_W-1:0]   mem [MAX_RADIX];
    logic               wr_en;
    logic [WIN_AW-1:0]  wr_addr;
    logic [VAL_W-1:0]   wr_data;
    logic               rd_en;
    logic [WIN_AW-1:0]  rd_addr;

    logic [VAL_W-1:0]   digit;
    logic [VAL_W-1:0]   mac;
    logic [VAL_W-1:0]   fib_sum;
    logic [VAL_W-1:0]   build_val;

    assign r_eff = (radix_reg > RADIX_W'(MAX_RADIX)) ? RADIX_W'(MAX_RADIX) : radix_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_reg   <= ENC_DIRECT;
            radix_reg <= RADIX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENCODING: enc_reg   <= enc_t'(cfg_data[ENC_W-1:0]);
                REG_RADIX:    radix_reg <= cfg_data[RADIX_W-1:0];
            endcase
        end
    end

    // Digit for the radix encodings; the gray digit wraps like the arithmetic does
    always_comb
    begin
        case (enc_reg)
            ENC_GRAY:   digit = par_reg ? (VAL_W'(r_eff) - 1'b1 - VAL_W'(symbol))
                                        : VAL_W'(symbol);
            ENC_UNIQUE: digit = VAL_W'(symbol) + 1'b1;
            default:    digit = VAL_W'(symbol);
        endcase
        mac = VAL_W'(acc_reg * VAL_W'(r_eff)) + digit;
        fib_sum = acc_reg + (({1'b0, sym_reg} < r_eff) ? rdata_reg : '0);

        if (r_eff < RADIX_W'(3) || cmd.idx == '0)
            build_val = '0;
        else if (cmd.idx == WIN_AW'(1))
            build_val = VAL_W'(1);
        else if (cmd.idx == WIN_AW'(2))
            build_val = VAL_W'(2);
        else if (RADIX_W'(cmd.idx) < r_eff)
            build_val = a_reg + b_reg;
        else
            build_val = '0;
    end

    always_comb
    begin
        acc_next  = acc_reg;
        par_next  = par_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        outv_next = outv_reg && !out_ready;
        outd_next = outd_reg;
        wr_en     = 1'b0;
        wr_addr   = cmd.idx;
        wr_data   = '0;
        rd_en     = 1'b0;
        rd_addr   = symbol;

        unique case (cmd.op)
            OP_NONE:
            begin
            end
            OP_TAKE:
            begin
                if (enc_reg == ENC_FIB)
                begin
                    rd_en = 1'b1;
                end
                else
                begin
                    acc_next = mac;
                    if (enc_reg == ENC_GRAY)
                        par_next = par_reg ^ symbol[0];
                end
                if (final_symbol && !(enc_reg == ENC_FIB && r_eff >= RADIX_W'(3)))
                begin
                    outv_next = 1'b1;
                    outd_next = (enc_reg == ENC_FIB) ? acc_reg : mac;
                    acc_next  = '0;
                    par_next  = 1'b0;
                end
            end
            OP_FIB_ADD:
            begin
                rd_en   = 1'b1;
                rd_addr = WIN_AW'(r_eff - RADIX_W'(2));
                if (last_reg)
                begin
                    outv_next = 1'b1;
                    outd_next = fib_sum;
                    acc_next  = '0;
                    par_next  = 1'b0;
                end
                else
                    acc_next = fib_sum;
            end
            OP_FIB_RD2:
            begin
                b_next  = rdata_reg;
                rd_en   = 1'b1;
                rd_addr = WIN_AW'(r_eff - RADIX_W'(1));
            end
            OP_FIB_RD1:
            begin
                // radix three: entry 1 takes the freshly updated entry 2
                a_next  = (r_eff == RADIX_W'(3)) ? (b_reg + rdata_reg) : rdata_reg;
                b_next  = b_reg + rdata_reg;
                wr_en   = 1'b1;
                wr_addr = WIN_AW'(1);
                wr_data = a_next;
            end
            OP_FIB_W2:
            begin
                wr_en   = 1'b1;
                wr_addr = WIN_AW'(2);
                wr_data = b_reg;
            end
            OP_FIB_REC:
            begin
                wr_en   = 1'b1;
                wr_data = a_reg + b_reg;
                a_next  = b_reg;
                b_next  = a_reg + b_reg;
            end
            OP_BUILD:
            begin
                wr_en   = 1'b1;
                wr_data = build_val;
                a_next  = b_reg;
                b_next  = build_val;
            end
        endcase

        // a register write abandons the label
        if (cfg_we)
        begin
            acc_next = '0;
            par_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            par_reg  <= 1'b0;
            outv_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            par_reg  <= par_next;
            outv_reg <= outv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        outd_reg <= outd_next;
        if (cmd.op == OP_TAKE)
        begin
            sym_reg  <= symbol;
            last_reg <= final_symbol;
        end
    end

    // Window memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    assign status.fib_mode  = (enc_reg == ENC_FIB) && (r_eff >= RADIX_W'(3));
    assign status.radix_is3 = (r_eff == RADIX_W'(3));
    assign status.radix_eff = r_eff;
    assign status.out_free  = !outv_reg || out_ready;
    assign status.last      = last_reg;
    assign status.cfg_hit   = cfg_we;

    assign out_valid   = outv_reg;
    assign label_value = outd_reg;

endmodule

`default_nettype wire

// ===== hdl/slti_ctrl.sv =====
// Controller: sequences item intake, window lookup, window advance and rebuild.
`default_nettype none

module slti_ctrl
    import slti_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire dp_status_t  status,
    output dp_cmd_t          cmd
);

    state_t             state_reg, state_next;
    logic [WIN_AW-1:0]  idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BUILD;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        in_ready   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.idx    = idx_reg;

        unique case (state_reg)
            ST_BUILD:
            begin
                cmd.op = OP_BUILD;
                if (idx_reg == WIN_AW'(MAX_RADIX - 1))
                    state_next = ST_IDLE;
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_IDLE:
            begin
                in_ready = status.out_free;
                if (in_valid && status.out_free)
                begin
                    cmd.op = OP_TAKE;
                    if (status.fib_mode)
                        state_next = ST_FIB_ADD;
                end
            end
            ST_FIB_ADD:
            begin
                cmd.op = OP_FIB_ADD;
                if (status.last)
                begin
                    // label done: window goes back to its starting values
                    state_next = ST_BUILD;
                    idx_next   = '0;
                end
                else
                    state_next = ST_FIB_RD2;
            end
            ST_FIB_RD2:
            begin
                cmd.op     = OP_FIB_RD2;
                state_next = ST_FIB_RD1;
            end
            ST_FIB_RD1:
            begin
                cmd.op     = OP_FIB_RD1;
                state_next = ST_FIB_W2;
            end
            ST_FIB_W2:
            begin
                cmd.op = OP_FIB_W2;
                if (status.radix_is3)
                    state_next = ST_IDLE;
                else
                begin
                    state_next = ST_FIB_REC;
                    idx_next   = WIN_AW'(3);
                end
            end
            ST_FIB_REC:
            begin
                cmd.op = OP_FIB_REC;
                if (RADIX_W'(idx_reg) == status.radix_eff - 1'b1)
                    state_next = ST_IDLE;
                else
                    idx_next = idx_reg + 1'b1;
            end
            default:
            begin
                state_next = ST_BUILD;
                idx_next   = '0;
            end
        endcase

        if (status.cfg_hit)
        begin
            state_next = ST_BUILD;
            idx_next   = '0;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/symbol_label_to_integer_unit.sv =====
// Top level of the symbol label to integer unit.
//
//  channel  dir  handshake                    payload
//  s_axis   in   s_axis_tvalid/s_axis_tready  tdata[3:0] symbol, tlast final_symbol
//  m_axis   out  m_axis_tvalid/m_axis_tready  tdata[31:0] label_value
//  cfg      in   cfg_we                       cfg_index, cfg_data
//
//  Radix modes and fibonacci mode with radix below 3: one cycle per item.
//  Fibonacci mode (r = effective radix): a non-final item is taken and added,
//  entries r - 2 and r - 1 read, 1 and 2 written and 3 to r - 1 recomputed
//  through the window's single write port; a final item is taken and added,
//  then all 16 entries rebuilt, as after reset and after each register write,
//  with no item taken meanwhile. A waiting result blocks only a further item.
`default_nettype none

module symbol_label_to_integer_unit
    import slti_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,   // [3:0] symbol, [7:4] zero
    input  wire logic               s_axis_tlast,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [VAL_W-1:0]        m_axis_tdata,   // [31:0] label_value
    input  wire logic               cfg_we,
    input  wire logic [CFG_IW-1:0]  cfg_index,
    input  wire logic [CFG_DW-1:0]  cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    slti_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    slti_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .symbol       (s_axis_tdata[SYM_W-1:0]),
        .final_symbol (s_axis_tlast),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .label_value  (m_axis_tdata)
    );

    // an item is only taken when the result register can take its result
    a_ready_slot: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
        else $error("item taken while result register occupied");

    // a register write starts a window rebuild
    a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !s_axis_tready)
        else $error("item taken during window rebuild");

    // a non-final item never produces a result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tlast && !m_axis_tvalid)
        |=> !m_axis_tvalid)
        else $error("result from non-final item");

endmodule

`default_nettype wire
